// ----- hdl/ght_pkg.sv -----
// Shared constants, codes and helpers for the generational handle table.
// Row and address sizes follow from SLOTS; used by ght_ram users and generational_handle_table.
// No dependencies.
package ght_pkg;

	localparam int SLOTS    = 1024;
	localparam int ROW_W    = 32;                      // occupancy bits per memory row
	localparam int ROW_BITS = 5;                       // log2(ROW_W)
	localparam int ROWS     = (SLOTS + ROW_W - 1) / ROW_W;
	localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ROW_DEPTH = (ROWS > 1) ? ROWS : 2;
	localparam int SLOT_AW  = $clog2(SLOTS);
	localparam int COUNT_W  = $clog2(SLOTS + 1);
	localparam int GEN_W    = 16;
	localparam int IDX_W    = 16;
	localparam int OBJ_W    = 16;
	localparam int HDL_W    = GEN_W + IDX_W;
	localparam int ENTRY_W  = GEN_W + OBJ_W;            // stored generation above object
	localparam int LIVE_W   = 11;

	typedef enum logic [2:0] {
		OP_ALLOC  = 3'd0,
		OP_INSERT = 3'd1,
		OP_LOOKUP = 3'd2,
		OP_REMOVE = 3'd3,
		OP_TEST   = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BAD      = 3'd2,
		ST_OCCUPIED = 3'd3,
		ST_MISS     = 3'd4
	} status_t;

	// generation wraps past all ones to 1, never 0
	function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
		logic [GEN_W-1:0] n;
		n = g + 1'b1;
		return (n == '0) ? GEN_W'(1) : n;
	endfunction

	// bit positions of a row that lie beyond the last slot read as taken
	function automatic logic [ROW_W-1:0] pad_mask(input logic [ROW_AW-1:0] row);
		logic [ROW_W-1:0] m;
		for (int b = 0; b < ROW_W; b++) begin
			m[b] = ((int'(row) * ROW_W + b) >= SLOTS);
		end
		return m;
	endfunction

endpackage

// ----- hdl/ght_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module ght_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/generational_handle_table.sv -----
// Generational handle table: slot occupancy and slot entries held in two ght_ram memories.
// Depends on ght_pkg and ght_ram.
//
//  channel | signals                                              | direction
//  req     | req_valid, req_stall, operation, handle_in,          | in
//          | object_ref, check_match                              |
//  rsp     | rsp_valid, rsp_stall, status, handle_out,            | out
//          | object_out, hit, live_count                          |
//
// Each word is accepted with its memory read, then decoded, written back and answered.
// Clear: accept, then one occupancy row zeroed per cycle, holding on the last row while
// a stalled result still waits in the output register.
// After reset the same sweep runs; req_stall stays high meanwhile.
// A stalled result waits in the output register; the next word is taken meanwhile
// and its result waits in the decode cycle until the register frees up.
module generational_handle_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  operation,
	input  logic [31:0] handle_in,
	input  logic [15:0] object_ref,
	input  logic        check_match,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [31:0] handle_out,
	output logic [15:0] object_out,
	output logic        hit,
	output logic [10:0] live_count
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ
	} state_t;

	state_t                          state_q;
	logic [ght_pkg::ROW_AW-1:0]      clr_row_q;
	logic                            clr_rsp_q;
	logic [ght_pkg::ROWS-1:0]        row_full_q;
	logic [ght_pkg::GEN_W-1:0]       gen_q;
	logic [ght_pkg::COUNT_W-1:0]     cnt_q;

	ght_pkg::op_t                    op_s1;
	logic [ght_pkg::HDL_W-1:0]       hdl_s1;
	logic [ght_pkg::OBJ_W-1:0]       obj_s1;
	logic                            chk_s1;
	logic [ght_pkg::ROW_AW-1:0]      row_s1;
	logic                            full_s1;

	logic                            rsp_valid_q;
	ght_pkg::status_t                status_q;
	logic [ght_pkg::HDL_W-1:0]       hout_q;
	logic [ght_pkg::OBJ_W-1:0]       oout_q;
	logic                            hit_q;

	// memory ports
	logic                            vr_we;
	logic [ght_pkg::ROW_AW-1:0]      vr_waddr;
	logic [ght_pkg::ROW_W-1:0]       vr_wdata;
	logic [ght_pkg::ROW_AW-1:0]      vr_raddr;
	logic [ght_pkg::ROW_W-1:0]       vr_rdata;
	logic                            er_we;
	logic [ght_pkg::SLOT_AW-1:0]     er_waddr;
	logic [ght_pkg::ENTRY_W-1:0]     er_wdata;
	logic [ght_pkg::SLOT_AW-1:0]     er_raddr;
	logic [ght_pkg::ENTRY_W-1:0]     er_rdata;

	// decode-cycle results
	logic                            accept;
	logic                            out_free;
	logic                            rsp_load;
	logic [ght_pkg::ROW_AW-1:0]      free_row;
	logic                            all_full;
	logic [ght_pkg::ROW_AW-1:0]      req_row;
	logic [ght_pkg::ROW_W-1:0]       pad;
	logic [ght_pkg::ROW_W-1:0]       free_bits;
	logic [ght_pkg::ROW_BITS-1:0]    free_bit;
	logic [ght_pkg::ROW_BITS-1:0]    bpos;
	logic [ght_pkg::IDX_W-1:0]       idx;
	logic [ght_pkg::IDX_W-1:0]       alloc_idx;
	logic                            in_range;
	logic                            slot_taken;
	logic [ght_pkg::HDL_W-1:0]       stored_hdl;
	logic [ght_pkg::ROW_W-1:0]       new_word;
	logic                            row_set;
	logic                            row_clr;
	logic                            gen_adv;
	logic                            cnt_inc;
	logic                            cnt_dec;
	ght_pkg::status_t                d_status;
	logic [ght_pkg::HDL_W-1:0]       d_hout;
	logic [ght_pkg::OBJ_W-1:0]       d_oout;
	logic                            d_hit;

	ght_ram #(.WIDTH(ght_pkg::ROW_W), .DEPTH(ght_pkg::ROW_DEPTH)) u_valid_ram (
		.clk   (clk),
		.we    (vr_we),
		.waddr (vr_waddr),
		.wdata (vr_wdata),
		.raddr (vr_raddr),
		.rdata (vr_rdata)
	);

	ght_ram #(.WIDTH(ght_pkg::ENTRY_W), .DEPTH(ght_pkg::SLOTS)) u_entry_ram (
		.clk   (clk),
		.we    (er_we),
		.waddr (er_waddr),
		.wdata (er_wdata),
		.raddr (er_raddr),
		.rdata (er_rdata)
	);

	assign req_stall  = (state_q != S_IDLE);
	assign accept     = req_valid && (state_q == S_IDLE);
	assign out_free   = !rsp_valid_q || !rsp_stall;

	// a new result enters the output register this cycle
	assign rsp_load   = out_free && ((state_q == S_READ) ||
	                    (state_q == S_CLEAR && clr_rsp_q &&
	                     clr_row_q == ght_pkg::ROW_AW'(ght_pkg::ROWS - 1)));

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign handle_out = hout_q;
	assign object_out = oout_q;
	assign hit        = hit_q;
	assign live_count = ght_pkg::LIVE_W'(cnt_q);

	// lowest row that still has a free slot
	always_comb begin
		free_row = '0;
		for (int r = ght_pkg::ROWS - 1; r >= 0; r--) begin
			if (!row_full_q[r]) begin
				free_row = ght_pkg::ROW_AW'(r);
			end
		end
		all_full = &row_full_q;
	end

	assign req_row  = (ght_pkg::op_t'(operation) == ght_pkg::OP_ALLOC) ? free_row :
	                  ght_pkg::ROW_AW'(handle_in[ght_pkg::IDX_W-1:ght_pkg::ROW_BITS]);
	assign vr_raddr = (state_q == S_IDLE) ? req_row : row_s1;
	assign er_raddr = (state_q == S_IDLE) ? ght_pkg::SLOT_AW'(handle_in[ght_pkg::IDX_W-1:0]) :
	                  ght_pkg::SLOT_AW'(hdl_s1[ght_pkg::IDX_W-1:0]);

	// lowest free bit of the fetched row
	assign pad       = ght_pkg::pad_mask(row_s1);
	assign free_bits = ~(vr_rdata | pad);
	always_comb begin
		free_bit = '0;
		for (int b = ght_pkg::ROW_W - 1; b >= 0; b--) begin
			if (free_bits[b]) begin
				free_bit = ght_pkg::ROW_BITS'(b);
			end
		end
	end

	assign idx        = hdl_s1[ght_pkg::IDX_W-1:0];
	assign alloc_idx  = ght_pkg::IDX_W'({row_s1, free_bit});
	assign in_range   = ({1'b0, idx} < 17'(ght_pkg::SLOTS));
	assign bpos       = (op_s1 == ght_pkg::OP_ALLOC) ? free_bit : idx[ght_pkg::ROW_BITS-1:0];
	assign slot_taken = vr_rdata[bpos];
	assign stored_hdl = {er_rdata[ght_pkg::ENTRY_W-1:ght_pkg::OBJ_W], idx};

	always_comb begin
		d_status = ght_pkg::ST_OK;
		d_hout   = '0;
		d_oout   = '0;
		d_hit    = 1'b0;
		row_set  = 1'b0;
		row_clr  = 1'b0;
		gen_adv  = 1'b0;
		cnt_inc  = 1'b0;
		cnt_dec  = 1'b0;
		er_wdata = {hdl_s1[ght_pkg::HDL_W-1:ght_pkg::IDX_W], obj_s1};
		er_waddr = ght_pkg::SLOT_AW'(idx);
		unique case (op_s1)
			ght_pkg::OP_ALLOC: begin
				if (full_s1 || free_bits == '0) begin
					d_status = ght_pkg::ST_FULL;
				end else begin
					d_hout   = {gen_q, alloc_idx};
					er_wdata = {gen_q, obj_s1};
					er_waddr = ght_pkg::SLOT_AW'(alloc_idx);
					row_set  = 1'b1;
					gen_adv  = 1'b1;
					cnt_inc  = 1'b1;
				end
			end
			ght_pkg::OP_INSERT: begin
				if (hdl_s1 == '0 || !in_range) begin
					d_status = ght_pkg::ST_BAD;
				end else if (slot_taken) begin
					d_status = ght_pkg::ST_OCCUPIED;
				end else begin
					row_set = 1'b1;
					cnt_inc = 1'b1;
				end
			end
			ght_pkg::OP_LOOKUP: begin
				if (hdl_s1 == '0 || !in_range) begin
					d_status = ght_pkg::ST_BAD;
				end else if (slot_taken && (!chk_s1 || stored_hdl == hdl_s1)) begin
					d_hit  = 1'b1;
					d_hout = stored_hdl;
					d_oout = er_rdata[ght_pkg::OBJ_W-1:0];
				end else begin
					d_status = ght_pkg::ST_MISS;
				end
			end
			ght_pkg::OP_REMOVE: begin
				if (!in_range) begin
					d_status = ght_pkg::ST_BAD;
				end else if (slot_taken && er_rdata[ght_pkg::OBJ_W-1:0] == obj_s1) begin
					row_clr = 1'b1;
					cnt_dec = (cnt_q != '0);
				end else begin
					d_status = ght_pkg::ST_MISS;
				end
			end
			ght_pkg::OP_TEST: begin
				if (!in_range) begin
					d_status = ght_pkg::ST_BAD;
				end else begin
					d_hit = slot_taken;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		new_word = vr_rdata;
		if (row_set) begin
			new_word[bpos] = 1'b1;
		end else if (row_clr) begin
			new_word[bpos] = 1'b0;
		end
	end

	// memory writes: clearing sweep, or write-back when the decode cycle retires
	always_comb begin
		vr_we    = 1'b0;
		vr_waddr = row_s1;
		vr_wdata = new_word;
		er_we    = 1'b0;
		if (state_q == S_CLEAR) begin
			vr_we    = 1'b1;
			vr_waddr = clr_row_q;
			vr_wdata = '0;
		end else if (state_q == S_READ && out_free) begin
			vr_we = row_set || row_clr;
			er_we = row_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_row_q   <= '0;
			clr_rsp_q   <= 1'b0;
			row_full_q  <= '0;
			gen_q       <= ght_pkg::GEN_W'(1);
			cnt_q       <= '0;
			op_s1       <= ght_pkg::OP_ALLOC;
			hdl_s1      <= '0;
			obj_s1      <= '0;
			chk_s1      <= 1'b0;
			row_s1      <= '0;
			full_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
			status_q    <= ght_pkg::ST_OK;
			hout_q      <= '0;
			oout_q      <= '0;
			hit_q       <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (clr_row_q == ght_pkg::ROW_AW'(ght_pkg::ROWS - 1)) begin
						if (!clr_rsp_q || out_free) begin
							state_q    <= S_IDLE;
							row_full_q <= '0;
							cnt_q      <= '0;
							if (clr_rsp_q) begin
								status_q    <= ght_pkg::ST_OK;
								hout_q      <= '0;
								oout_q      <= '0;
								hit_q       <= 1'b0;
							end
						end
					end else begin
						clr_row_q <= clr_row_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_s1   <= ght_pkg::op_t'(operation);
						hdl_s1  <= handle_in;
						obj_s1  <= object_ref;
						chk_s1  <= check_match;
						row_s1  <= req_row;
						full_s1 <= all_full;
						if (ght_pkg::op_t'(operation) == ght_pkg::OP_CLEAR) begin
							state_q   <= S_CLEAR;
							clr_row_q <= '0;
							clr_rsp_q <= 1'b1;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (out_free) begin
						state_q     <= S_IDLE;
						status_q    <= d_status;
						hout_q      <= d_hout;
						oout_q      <= d_oout;
						hit_q       <= d_hit;
						if (row_set || row_clr) begin
							row_full_q[row_s1] <= &(new_word | pad);
						end
						if (gen_adv) begin
							gen_q <= ght_pkg::next_gen(gen_q);
						end
						if (cnt_inc) begin
							cnt_q <= cnt_q + 1'b1;
						end else if (cnt_dec) begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
